FILE: sv/gic_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package gic_pkg;

    localparam int MAX_INTERVALS_DEF = 1024;
    localparam int COORD_WIDTH_DEF   = 32;
    localparam int COUNT_WIDTH       = 11;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_INIT,
        ST_SCAN,
        ST_DRAIN,
        ST_EVAL,
        ST_OUT
    } gic_state_t;

    typedef struct packed {
        logic load;      // store accepted item
        logic init;      // start cover run
        logic issue;     // read next entry
        logic advance;   // take best, start next pass
        logic finish_ok;
        logic finish_fail;
    } gic_cmd_t;

    typedef struct packed {
        logic issue_done;
        logic found;
        logic reach;     // best reaches target
        logic stall;     // best does not pass covered point
    } gic_status_t;

endpackage
`default_nettype wire

FILE: sv/gic_item_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface gic_item_if #(
    parameter int CW = 32
);
    logic                 valid;
    logic                 ready;
    logic signed [CW-1:0] interval_low;
    logic signed [CW-1:0] interval_high;
    logic                 last_interval;

    modport source (output valid, interval_low, interval_high, last_interval, input ready);
    modport sink   (input valid, interval_low, interval_high, last_interval, output ready);
endinterface
`default_nettype wire

FILE: sv/gic_result_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface gic_result_if;
    logic        valid;
    logic        ready;
    logic        covered;
    logic [10:0] chosen_count;

    modport source (output valid, covered, chosen_count, input ready);
    modport sink   (input valid, covered, chosen_count, output ready);
endinterface
`default_nettype wire

FILE: sv/gic_cfg_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface gic_cfg_if #(
    parameter int CW = 32
);
    logic                 valid;
    logic                 ready;
    logic signed [CW-1:0] target_length;

    modport source (output valid, target_length, input ready);
    modport sink   (input valid, target_length, output ready);
endinterface
`default_nettype wire

FILE: sv/gic_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module gic_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

FILE: sv/gic_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module gic_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    input  wire logic                 in_last,
    output logic                      in_ready,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    input  wire gic_pkg::gic_status_t status,
    output gic_pkg::gic_cmd_t         cmd
);
    import gic_pkg::*;

    gic_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            ST_LOAD:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (in_last)
                    begin
                        state_next = ST_INIT;
                    end
                end
            end
            ST_INIT:
            begin
                cmd.init   = 1'b1;
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (status.issue_done)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    cmd.issue = 1'b1;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                if (!status.found)
                begin
                    cmd.finish_fail = 1'b1;
                    state_next      = ST_OUT;
                end
                else if (status.reach)
                begin
                    cmd.finish_ok = 1'b1;
                    state_next    = ST_OUT;
                end
                else if (status.stall)
                begin
                    cmd.finish_fail = 1'b1;
                    state_next      = ST_OUT;
                end
                else
                begin
                    cmd.advance = 1'b1;
                    state_next  = ST_SCAN;
                end
            end
            ST_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end
endmodule
`default_nettype wire

FILE: sv/gic_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module gic_datapath #(
    parameter int MAX_INTERVALS = 1024,
    parameter int COORD_WIDTH   = 32
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire gic_pkg::gic_cmd_t             cmd,
    output gic_pkg::gic_status_t               status,
    input  wire logic signed [COORD_WIDTH-1:0] in_low,
    input  wire logic signed [COORD_WIDTH-1:0] in_high,
    input  wire logic                          cfg_we,
    input  wire logic signed [COORD_WIDTH-1:0] cfg_target,
    output logic                               covered,
    output logic [gic_pkg::COUNT_WIDTH-1:0]    chosen_count
);
    import gic_pkg::*;

    localparam int CW   = COORD_WIDTH;
    localparam int AW   = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
    localparam int CNTW = $clog2(MAX_INTERVALS + 1);

    logic [CNTW-1:0]        count_reg, idx_reg, pick_reg;
    logic                   rd_valid_reg, found_reg;
    logic signed [CW-1:0]   cov_reg, best_reg, target_reg;
    logic                   covered_reg;
    logic [COUNT_WIDTH-1:0] chosen_reg;
    logic [2*CW-1:0]        rdata;
    logic signed [CW-1:0]   rd_low, rd_high;
    logic                   we, hit;
    logic [CNTW-1:0]        pick_inc;

    assign we       = cmd.load && (count_reg < CNTW'(MAX_INTERVALS));
    assign rd_low   = rdata[CW-1:0];
    assign rd_high  = rdata[2*CW-1:CW];
    assign pick_inc = pick_reg + CNTW'(1);
    assign hit      = rd_valid_reg && (rd_low <= cov_reg)
                      && (!found_reg || (rd_high > best_reg));

    gic_ram #(
        .WIDTH (2 * CW),
        .DEPTH (MAX_INTERVALS),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (count_reg[AW-1:0]),
        .wdata ({in_high, in_low}),
        .raddr (idx_reg[AW-1:0]),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            idx_reg      <= '0;
            pick_reg     <= '0;
            rd_valid_reg <= 1'b0;
            found_reg    <= 1'b0;
            cov_reg      <= '0;
            target_reg   <= '0;
        end
        else
        begin
            rd_valid_reg <= cmd.issue;
            if (cfg_we)
            begin
                target_reg <= cfg_target;
            end
            if (we)
            begin
                count_reg <= count_reg + CNTW'(1);
            end
            if (cmd.issue)
            begin
                idx_reg <= idx_reg + CNTW'(1);
            end
            if (hit)
            begin
                found_reg <= 1'b1;
            end
            if (cmd.init)
            begin
                idx_reg   <= '0;
                found_reg <= 1'b0;
                cov_reg   <= '0;
                pick_reg  <= '0;
            end
            if (cmd.advance)
            begin
                idx_reg   <= '0;
                found_reg <= 1'b0;
                cov_reg   <= best_reg;
                pick_reg  <= pick_inc;
            end
            if (cmd.finish_ok || cmd.finish_fail)
            begin
                count_reg <= '0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (hit)
        begin
            best_reg <= rd_high;
        end
        if (cmd.finish_ok)
        begin
            covered_reg <= 1'b1;
            chosen_reg  <= COUNT_WIDTH'(pick_inc);
        end
        else if (cmd.finish_fail)
        begin
            covered_reg <= 1'b0;
            chosen_reg  <= '0;
        end
    end

    assign status.issue_done = (idx_reg == count_reg);
    assign status.found      = found_reg;
    assign status.reach      = (best_reg >= target_reg);
    assign status.stall      = (best_reg <= cov_reg);
    assign covered           = covered_reg;
    assign chosen_count      = chosen_reg;
endmodule
`default_nettype wire

FILE: sv/greedy_interval_cover_core.sv
// Each greedy pass over the N loaded intervals issues N reads through the single
// registered read port of the interval memory, then takes the last read data,
// drains and evaluates. A run that chooses P intervals makes P passes; a run that
// fails after k advances makes k + 1 passes.
// Loading takes one item per cycle; no item is taken while a run or result is pending.
// Reset (rst_n, async low) empties the set and clears target_length; memory not cleared.
`timescale 1ns / 1ps
`default_nettype none
module greedy_interval_cover_core #(
    parameter int MAX_INTERVALS = gic_pkg::MAX_INTERVALS_DEF,
    parameter int COORD_WIDTH   = gic_pkg::COORD_WIDTH_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    gic_item_if.sink   item,
    gic_result_if.source result,
    gic_cfg_if.sink    cfg
);
    import gic_pkg::*;

    gic_cmd_t    cmd;
    gic_status_t status;

    assign cfg.ready = 1'b1;

    gic_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item.valid),
        .in_last   (item.last_interval),
        .in_ready  (item.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .status    (status),
        .cmd       (cmd)
    );

    gic_datapath #(
        .MAX_INTERVALS (MAX_INTERVALS),
        .COORD_WIDTH   (COORD_WIDTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .in_low       (item.interval_low),
        .in_high      (item.interval_high),
        .cfg_we       (cfg.valid),
        .cfg_target   (cfg.target_length),
        .covered      (result.covered),
        .chosen_count (result.chosen_count)
    );
endmodule
`default_nettype wire

FILE: sv/gic_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module gic_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic        covered,
    input wire logic [10:0] chosen_count
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped before taken");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !covered |-> chosen_count == 11'd0)
        else $error("count nonzero on failure");

    a_ok_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && covered |-> chosen_count != 11'd0)
        else $error("zero count on success");

    a_no_load_pending: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("item taken while result pending");
endmodule

bind greedy_interval_cover_core gic_checker u_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ready     (item.ready),
    .out_valid    (result.valid),
    .out_ready    (result.ready),
    .covered      (result.covered),
    .chosen_count (result.chosen_count)
);
`default_nettype wire
